[design/bcbs_pkg.sv]
// Shared types and constants of the Bezier curve sampler.
// Holds the command/status structs joining controller and datapath and
// the binomial coefficient table. No dependencies.
package bcbs_pkg;

  localparam int SAMPLES_W = 6;
  localparam logic [SAMPLES_W-1:0] SAMPLES_RESET = 6'd50;

  // Q1.16 fraction
  localparam int FRAC_W = 16;
  localparam int Q16_W  = FRAC_W + 1;
  localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(1) << FRAC_W;

  // u = (k << 16) / s, resolved one quotient bit per cycle
  localparam int DIV_W     = SAMPLES_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int MAX_ORDER = 12;
  localparam int ORDER_W   = 4;
  localparam int BINOM_W   = 10;

  typedef logic [BINOM_W-1:0] binom_t;

  // C(n, j), row n, column j
  localparam binom_t BINOM [0:MAX_ORDER][0:MAX_ORDER] = '{
    '{10'd1, 10'd0,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd1,  10'd0,  10'd0,   10'd0,   10'd0,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd2,  10'd1,  10'd0,   10'd0,   10'd0,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd3,  10'd3,  10'd1,   10'd0,   10'd0,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd4,  10'd6,  10'd4,   10'd1,   10'd0,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd5,  10'd10, 10'd10,  10'd5,   10'd1,   10'd0,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd6,  10'd15, 10'd20,  10'd15,  10'd6,   10'd1,
      10'd0,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd7,  10'd21, 10'd35,  10'd35,  10'd21,  10'd7,
      10'd1,  10'd0,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd8,  10'd28, 10'd56,  10'd70,  10'd56,  10'd28,
      10'd8,  10'd1,   10'd0,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd9,  10'd36, 10'd84,  10'd126, 10'd126, 10'd84,
      10'd36, 10'd9,   10'd1,   10'd0,  10'd0,  10'd0},
    '{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210,
      10'd120, 10'd45, 10'd10,  10'd1,  10'd0,  10'd0},
    '{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462,
      10'd330, 10'd165, 10'd55, 10'd11, 10'd1,  10'd0},
    '{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924,
      10'd792, 10'd495, 10'd220, 10'd66, 10'd12, 10'd1}
  };

  typedef struct packed {
    logic load;      // store the incoming control point
    logic start;     // begin a curve, k = 0
    logic next;      // advance to the next curve point
    logic div_step;  // one quotient bit of u
    logic pv_step;   // one power of (1 - u)
    logic w1;        // u^j * (1-u)^(n-j)
    logic w2;        // scale by C(n, j)
    logic mac;       // accumulate weighted coordinates
    logic emit;      // load the output register
    logic clear;     // empty the point store
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic pv_done;
    logic j_last;
    logic k_last;
    logic out_free;
  } status_t;

endpackage

[design/bcbs_point_if.sv]
// Control point channel: valid/ready handshake plus point payload.
// Depends on nothing.
interface bcbs_point_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         final_point;

  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

[design/bcbs_curve_if.sv]
// Curve point channel: valid/ready handshake plus curve payload.
// Depends on nothing.
interface bcbs_curve_if #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] curve_x;
  logic signed [COORD_BITS-1:0] curve_y;
  logic signed [COORD_BITS-1:0] curve_z;
  logic                         end_of_curve;

  modport source (output valid, curve_x, curve_y, curve_z, end_of_curve, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, end_of_curve, output ready);
endinterface

[design/bcbs_ctrl.sv]
// Sequencer of the Bezier sampler: loads points, then steps the datapath
// through divide, power, weight and accumulate phases. Uses bcbs_pkg.
module bcbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_final,
  output logic              in_ready,
  input  bcbs_pkg::status_t status,
  output bcbs_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_PV    = 8'b0000_1000,
    ST_W1    = 8'b0001_0000,
    ST_W2    = 8'b0010_0000,
    ST_MAC   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_PV;
        end
      end
      ST_PV: begin
        cmd.pv_step = 1'b1;
        if (status.pv_done) begin
          state_next = ST_W1;
        end
      end
      ST_W1: begin
        cmd.w1     = 1'b1;
        state_next = ST_W2;
      end
      ST_W2: begin
        cmd.w2     = 1'b1;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac    = 1'b1;
        state_next = status.j_last ? ST_EMIT : ST_W1;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.k_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/bcbs_datapath.sv]
// Datapath of the Bezier sampler: point store, u divider, power chain,
// weight and coordinate multipliers, output register. Uses bcbs_pkg.
module bcbs_datapath #(
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic        [bcbs_pkg::SAMPLES_W-1:0] cfg_wr_data,
  input  logic signed [COORD_BITS-1:0]         pt_x,
  input  logic signed [COORD_BITS-1:0]         pt_y,
  input  logic signed [COORD_BITS-1:0]         pt_z,
  input  bcbs_pkg::cmd_t                       cmd,
  output bcbs_pkg::status_t                    status,
  bcbs_curve_if.source                         curve
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW     = bcbs_pkg::SAMPLES_W;
  localparam int FW     = bcbs_pkg::FRAC_W;
  localparam int QW     = bcbs_pkg::Q16_W;
  localparam int DW     = bcbs_pkg::DIV_W;
  localparam int DCW    = bcbs_pkg::DIV_CNT_W;
  localparam int BW     = bcbs_pkg::BINOM_W;
  localparam int OW     = bcbs_pkg::ORDER_W;
  // weight sum is at most 1.0, so this holds the sum plus rounding
  localparam int ACC_W  = COORD_BITS + QW + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FW - 1);

  // configuration and point store
  logic [SW-1:0]               samples;
  logic signed [COORD_BITS-1:0] ctrl_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ctrl_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ctrl_z [MAX_POINTS];
  logic [CNT_W-1:0]            points_loaded;
  logic                        store_full;

  // per-curve state
  logic [IDX_W-1:0] n;
  logic [SW-1:0]    s_eff;
  logic [SW-1:0]    k;
  logic [SW-1:0]    k_new;

  // u divider
  logic [DW-1:0]  dividend;
  logic [DW-1:0]  quo;
  logic [SW-1:0]  rem;
  logic [DCW-1:0] step;
  logic [SW:0]    rem_sh;
  logic           rem_ge;
  logic [QW-1:0]  u;
  logic [QW-1:0]  v;

  // powers and weights
  logic [QW-1:0]    pv [MAX_POINTS];
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [QW-1:0]    p_run;
  logic [QW-1:0]    pu_run;
  logic [QW-1:0]    t1;
  logic [QW-1:0]    w;
  logic [2*QW-1:0]  pv_prod;
  logic [2*QW-1:0]  pu_prod;
  logic [2*QW-1:0]  t1_prod;
  logic [BW+QW-1:0] w_prod;

  // accumulators
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
  logic signed [ACC_W-1:0] prod_x, prod_y, prod_z;
  logic signed [ACC_W-1:0] rnd_x, rnd_y, rnd_z;
  logic                    out_valid;

  assign store_full = (points_loaded >= CNT_W'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      samples <= bcbs_pkg::SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      samples <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_loaded <= '0;
    end else if (cmd.clear) begin
      points_loaded <= '0;
    end else if (cmd.load && !store_full) begin
      points_loaded <= points_loaded + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      ctrl_x[points_loaded[IDX_W-1:0]] <= pt_x;
      ctrl_y[points_loaded[IDX_W-1:0]] <= pt_y;
      ctrl_z[points_loaded[IDX_W-1:0]] <= pt_z;
    end
  end

  // restoring division, remainder stays below s
  assign rem_sh = {rem, dividend[DW-1]};
  assign rem_ge = (rem_sh >= {1'b0, s_eff});
  assign u      = quo[QW-1:0];
  assign v      = bcbs_pkg::Q16_ONE - u;
  assign k_new  = cmd.start ? '0 : k + SW'(1);

  assign pv_prod = p_run * v;
  assign pu_prod = pu_run * u;
  assign t1_prod = pu_run * pv[n - j];
  assign w_prod  = bcbs_pkg::BINOM[OW'(n)][OW'(j)] * t1;

  assign prod_x = $signed({1'b0, w}) * ctrl_x[j];
  assign prod_y = $signed({1'b0, w}) * ctrl_y[j];
  assign prod_z = $signed({1'b0, w}) * ctrl_z[j];

  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      n     <= '0;
      s_eff <= SW'(1);
      step  <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      if (cmd.start) begin
        n     <= IDX_W'(points_loaded - CNT_W'(1));
        s_eff <= (samples == '0) ? SW'(1) : samples;
      end
      if (cmd.start || cmd.next) begin
        k    <= k_new;
        step <= '0;
        i    <= '0;
        j    <= '0;
      end else begin
        if (cmd.div_step) begin
          step <= step + DCW'(1);
        end
        if (cmd.pv_step) begin
          i <= i + IDX_W'(1);
        end
        if (cmd.mac) begin
          j <= j + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.next) begin
      dividend <= {k_new, FW'(0)};
      quo      <= '0;
      rem      <= '0;
      p_run    <= bcbs_pkg::Q16_ONE;
      pu_run   <= bcbs_pkg::Q16_ONE;
      acc_x    <= '0;
      acc_y    <= '0;
      acc_z    <= '0;
    end else begin
      if (cmd.div_step) begin
        dividend <= dividend << 1;
        quo      <= {quo[DW-2:0], rem_ge};
        rem      <= rem_ge ? SW'(rem_sh - {1'b0, s_eff}) : SW'(rem_sh);
      end
      if (cmd.pv_step) begin
        pv[i] <= p_run;
        p_run <= pv_prod[FW +: QW];
      end
      if (cmd.w1) begin
        t1     <= t1_prod[FW +: QW];
        pu_run <= pu_prod[FW +: QW];
      end
      if (cmd.w2) begin
        w <= w_prod[QW-1:0];
      end
      if (cmd.mac) begin
        acc_x <= acc_x + prod_x;
        acc_y <= acc_y + prod_y;
        acc_z <= acc_z + prod_z;
      end
    end
  end

  // round to nearest, ties up
  assign rnd_x = acc_x + ROUND_HALF;
  assign rnd_y = acc_y + ROUND_HALF;
  assign rnd_z = acc_z + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (curve.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      curve.curve_x      <= rnd_x[FW +: COORD_BITS];
      curve.curve_y      <= rnd_y[FW +: COORD_BITS];
      curve.curve_z      <= rnd_z[FW +: COORD_BITS];
      curve.end_of_curve <= (k == s_eff);
    end
  end

  assign curve.valid = out_valid;

  assign status.div_done = (step == DCW'(DW - 1));
  assign status.pv_done  = (i == n);
  assign status.j_last   = (j == n);
  assign status.k_last   = (k == s_eff);
  assign status.out_free = !out_valid || curve.ready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || curve.ready))
    else $error("output item overwritten before it was taken");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    points_loaded <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_u_end: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> ((u == bcbs_pkg::Q16_ONE) == (k == s_eff)))
    else $error("u reaches one at the wrong curve point");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.k_last) |=> (points_loaded == '0))
    else $error("point store not emptied after the curve");
`endif

endmodule

[design/bezier_curve_bernstein_sampler.sv]
// Bezier curve sampler, Bernstein form. Control point items are taken one per cycle
// while idle. A final item starts the curve: each of the s+1 curve points (s = samples,
// or 1 when samples is zero) runs the divider for u, then one power step and three
// weight/MAC steps per stored point, then an emit step.
// No item is taken while a curve is being computed. Synchronous reset empties the store,
// clears the output valid and sets samples to 50.
module bezier_curve_bernstein_sampler #(
  parameter int MAX_POINTS = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bcbs_pkg::SAMPLES_W-1:0] cfg_wr_data,
  bcbs_point_if.sink                     points,
  bcbs_curve_if.source                   curve
);

  bcbs_pkg::cmd_t    cmd;
  bcbs_pkg::status_t status;

  bcbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_final (points.final_point),
    .in_ready (points.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bcbs_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pt_x        (points.point_x),
    .pt_y        (points.point_y),
    .pt_z        (points.point_z),
    .cmd         (cmd),
    .status      (status),
    .curve       (curve)
  );

endmodule

[tb/tb_bezier_curve_bernstein_sampler.sv]
// Self-checking bench for the Bernstein-form Bezier curve sampler.
// Drives control point items and checks every curve point against a local predictor.
// Depends on bcbs_pkg, bcbs_point_if, bcbs_curve_if and the sampler itself.
module tb_bezier_curve_bernstein_sampler;

  localparam int COORD_W     = 24;
  localparam int MAX_PTS     = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [COORD_W-1:0] coord_t;
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   fin;
  } ctrl_point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   eoc;
  } curve_point_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [bcbs_pkg::SAMPLES_W-1:0] cfg_wr_data;

  bcbs_point_if #(.COORD_BITS(COORD_W)) pt_if ();
  bcbs_curve_if #(.COORD_BITS(COORD_W)) cv_if ();

  bezier_curve_bernstein_sampler #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .points     (pt_if),
    .curve      (cv_if)
  );

  ctrl_point_t  pending_points[$];
  curve_point_t expected_curve[$];

  // predictor state
  coord_t ctrl_store [3][MAX_PTS];
  longint blend_weight [MAX_PTS];
  int     point_count;
  int     samples_cfg;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int hold_requests;
  int hold_served;
  int mismatch_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic longint q16_power(longint base, int e);
    longint p;
    p = 65536;
    repeat (e) p = (p * base) >> 16;
    return p;
  endfunction

  function automatic coord_t weighted_coord(int axis);
    longint acc;
    acc = 0;
    for (int j = 0; j < point_count; j++) begin
      acc += blend_weight[j] * longint'(ctrl_store[axis][j]);
    end
    acc = (acc + 32768) >>> 16;
    return acc[COORD_W-1:0];
  endfunction

  // Store one control point if there is room; a final item expands into s+1 curve points (s = samples, or 1 when zero).
  function automatic void take_control_point(ctrl_point_t p);
    int           s;
    int           n;
    longint       u;
    longint       v;
    longint       c;
    curve_point_t r;
    if (point_count < MAX_PTS) begin
      ctrl_store[0][point_count] = p.x;
      ctrl_store[1][point_count] = p.y;
      ctrl_store[2][point_count] = p.z;
      point_count++;
    end
    if (!p.fin) return;
    n = point_count - 1;
    s = (samples_cfg == 0) ? 1 : samples_cfg;
    for (int k = 0; k <= s; k++) begin
      u = (longint'(k) << 16) / s;
      v = 65536 - u;
      c = 1;
      for (int j = 0; j < point_count; j++) begin
        blend_weight[j] = c * ((q16_power(u, j) * q16_power(v, n - j)) >> 16);
        c = c * (n - j) / (j + 1);
      end
      r.x   = weighted_coord(0);
      r.y   = weighted_coord(1);
      r.z   = weighted_coord(2);
      r.eoc = (k == s);
      expected_curve = {expected_curve, r};
    end
    point_count = 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst && pt_if.valid && pt_if.ready) begin
      take_control_point(pending_points.pop_front());
    end
    if (rst) begin
      pt_if.valid       <= 1'b0;
      pt_if.point_x     <= '0;
      pt_if.point_y     <= '0;
      pt_if.point_z     <= '0;
      pt_if.final_point <= 1'b0;
    end else if (!pt_if.valid || pt_if.ready) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        pt_if.valid       <= 1'b1;
        pt_if.point_x     <= pending_points[0].x;
        pt_if.point_y     <= pending_points[0].y;
        pt_if.point_z     <= pending_points[0].z;
        pt_if.final_point <= pending_points[0].fin;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    curve_point_t got;
    curve_point_t want;
    if (!rst && cv_if.valid && cv_if.ready) begin
      got = '{cv_if.curve_x, cv_if.curve_y, cv_if.curve_z, cv_if.end_of_curve};
      if (expected_curve.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected curve item x=%0d y=%0d z=%0d eoc=%0b",
                   got.x, got.y, got.z, got.eoc);
        end
      end else begin
        want = expected_curve.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.eoc !== want.eoc) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: exp x=%0d y=%0d z=%0d e=%0b got x=%0d y=%0d z=%0d e=%0b",
                     want.x, want.y, want.z, want.eoc, got.x, got.y, got.z, got.eoc);
          end
        end
      end
    end
    cv_if.ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'($urandom_range(8191)) - coord_t'(4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic void push_point(coord_t x, coord_t y, coord_t z, logic fin);
    ctrl_point_t p;
    p = '{x, y, z, fin};
    pending_points = {pending_points, p};
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_points.size() != 0 || pt_if.valid || expected_curve.size() != 0);
    // a trailing non-final item may still be in flight
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_samples(int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[bcbs_pkg::SAMPLES_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    samples_cfg = value;
  endtask

  // Random curves: mostly 1..8 points, now and then more than the store holds.
  task automatic run_phase(int samples, int idle_pct, int stall_pct, int items, bit hold);
    int queued;
    int len;
    write_samples(samples);
    @(negedge clk);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    if (hold) hold_requests++;
    queued = 0;
    while (queued < items) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(MAX_PTS + 3, MAX_PTS + 1)
                                     : $urandom_range(MAX_PTS, 1);
      for (int i = 0; i < len; i++) begin
        push_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
      end
      queued += len;
    end
    wait_drained();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    samples_cfg     = bcbs_pkg::SAMPLES_RESET;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, at the reset sample count
    push_point(COORD_MAX, COORD_MIN, '0, 1'b1);            // single point
    push_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);     // straight line
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    for (int i = 0; i < MAX_PTS; i++) begin                // store exactly full
      push_point(i[0] ? COORD_MIN : COORD_MAX, i[0] ? COORD_MAX : COORD_MIN,
                 rand_coord(), i == MAX_PTS - 1);
    end
    for (int i = 0; i < MAX_PTS + 2; i++) begin            // overflow, last two dropped
      push_point(coord_t'(i * 4096), -coord_t'(i * 300), coord_t'(7 - i),
                 i == MAX_PTS + 1);
    end
    push_point(coord_t'(1), -coord_t'(1), coord_t'(3), 1'b0);  // rounding
    push_point(-coord_t'(2), coord_t'(2), '0, 1'b0);
    push_point(coord_t'(5), -coord_t'(5), coord_t'(1), 1'b1);
    wait_drained();

    run_phase(63, 72, 0, 16, 1'b0);
    run_phase(0, 0, 72, 16, 1'b0);      // zero behaves as one interval
    run_phase(1, 19, 19, 16, 1'b0);
    run_phase($urandom_range(12, 2), 0, 0, 16, 1'b1);
    run_phase($urandom_range(20, 1), 19, 19, 16, 1'b0);

    if (mismatch_count == 0 && expected_curve.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[bezier_curve_bernstein_sampler.f]
design/bcbs_pkg.sv
design/bcbs_point_if.sv
design/bcbs_curve_if.sv
design/bcbs_ctrl.sv
design/bcbs_datapath.sv
design/bezier_curve_bernstein_sampler.sv
tb/tb_bezier_curve_bernstein_sampler.sv
